// File: sv/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types and constants for the fit-policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

    localparam int OFFSET_BITS      = 20;
    localparam int KIB_BITS         = 11;
    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int CFG_INDEX_BITS   = 2;

    typedef enum logic [1:0] {
        FIT_FIRST  = 2'd0,
        FIT_BEST   = 2'd1,
        FIT_WORST  = 2'd2,
        FIT_UNUSED = 2'd3
    } fit_t;

    typedef enum logic [1:0] {
        CAUSE_NONE    = 2'd0,
        CAUSE_NO_FIT  = 2'd1,
        CAUSE_FULL    = 2'd2,
        CAUSE_UNKNOWN = 2'd3
    } cause_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_FIT_METHOD = 2'd0,
        REG_CHUNK_KIB  = 2'd1,
        REG_SPARE2     = 2'd2,
        REG_SPARE3     = 2'd3
    } cfg_reg_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHUP,
        ST_PUT,
        ST_FSCAN,
        ST_SHDN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                   action;
        logic [OFFSET_BITS-1:0] request_size;
        logic [OFFSET_BITS-1:0] block_offset;
    } req_t;

    typedef struct packed {
        logic                   ok;
        logic [OFFSET_BITS-1:0] payload_offset;
        logic [1:0]             fail_cause;
    } rsp_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
    } blk_t;

endpackage

// File: sv/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram
// Block table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fpba_ram #(
    parameter int DEPTH = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int WIDTH = $bits(fpba_pkg::blk_t)
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: sv/fit_policy_block_allocator_unit.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit
// Address-ordered block table with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// One request is handled at a time. An allocate streams the table through
// the single read port at one entry per cycle, then shifts the tail up by one
// entry per cycle and writes the new entry; a free scans to the match and
// shifts the rest down. Oversized requests, an unused fit method and a full
// table are rejected straight from idle, with no scan. The sentinel entry is
// never stored, so there is no clearing pass: writing chunk_kib resets the
// count at once.
module fit_policy_block_allocator_unit #(
    parameter int MAX_BLOCKS   = fpba_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = fpba_pkg::HEADER_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fpba_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [fpba_pkg::KIB_BITS-1:0]         cfg_data,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  fpba_pkg::req_t                        req,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output fpba_pkg::rsp_t                        rsp
);

    localparam int OB   = fpba_pkg::OFFSET_BITS;
    localparam int AW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int EW   = OB + 2;
    localparam int GW   = OB + 3;
    localparam int KB   = fpba_pkg::KIB_BITS;

    fpba_pkg::state_t      state_reg, state_next;
    logic [1:0]            fm_reg, fm_next;
    logic [KB-1:0]         kib_reg, kib_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         i_reg, i_next;
    logic [CW-1:0]         wa_reg, wa_next;
    logic                  rv_reg, rv_next;
    logic                  found_reg, found_next;
    logic [CW-1:0]         pick_reg, pick_next;
    logic signed [GW-1:0]  pg_reg, pg_next;
    logic [EW-1:0]         here_reg, here_next;
    fpba_pkg::blk_t        cur_reg, cur_next;
    fpba_pkg::req_t        q_reg, q_next;
    fpba_pkg::rsp_t        res_reg, res_next;
    logic                  ov_reg, ov_next;
    fpba_pkg::rsp_t        out_reg, out_next;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    fpba_pkg::blk_t        mem_wdata;
    logic [AW-1:0]         mem_raddr;
    fpba_pkg::blk_t        mem_rdata;

    logic [33:0]           kib_bytes;
    logic [33:0]           byte_lim;
    logic [OB:0]           chunk;
    logic [EW-1:0]         cur_end;
    logic [EW-1:0]         limit;
    logic signed [GW-1:0]  gap;
    logic signed [GW-1:0]  need;
    logic                  take;
    logic                  last;

    fpba_ram #(
        .DEPTH (MAX_BLOCKS),
        .WIDTH ($bits(fpba_pkg::blk_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        kib_bytes = 34'(kib_reg) << 10;
        byte_lim  = 34'(1) << OB;
        chunk     = (OB+1)'((kib_bytes > byte_lim) ? byte_lim : kib_bytes);
        cur_end   = EW'(cur_reg.start) + EW'(HEADER_BYTES) + EW'(cur_reg.len);
        limit     = rv_reg ? EW'(mem_rdata.start) : EW'(chunk);
        gap       = $signed({1'b0, limit}) - $signed({1'b0, cur_end});
        need      = $signed({1'b0, EW'(q_reg.request_size) + EW'(HEADER_BYTES)});
        take      = (gap >= need) && (!found_reg
                    || (fm_reg == fpba_pkg::FIT_BEST  && gap < pg_reg)
                    || (fm_reg == fpba_pkg::FIT_WORST && gap > pg_reg));
        last      = !rv_reg && ((i_reg + CW'(1)) >= count_reg);
    end

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != fpba_pkg::ST_IDLE);
    assign rsp_valid = ov_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next = state_reg;
        fm_next    = fm_reg;
        kib_next   = kib_reg;
        count_next = count_reg;
        i_next     = i_reg;
        wa_next    = wa_reg;
        rv_next    = rv_reg;
        found_next = found_reg;
        pick_next  = pick_reg;
        pg_next    = pg_reg;
        here_next  = here_reg;
        cur_next   = cur_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        ov_next    = ov_reg && rsp_stall;
        out_next   = out_reg;
        mem_we     = 1'b0;
        mem_waddr  = wa_reg[AW-1:0];
        mem_wdata  = mem_rdata;
        mem_raddr  = '0;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == fpba_pkg::REG_FIT_METHOD)
            begin
                fm_next = cfg_data[1:0];
            end
            else if (cfg_index == fpba_pkg::REG_CHUNK_KIB)
            begin
                kib_next   = cfg_data;
                count_next = CW'(1);
            end
        end

        unique case (state_reg)
            fpba_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    q_next     = req;
                    res_next   = '0;
                    i_next     = '0;
                    rv_next    = 1'b0;
                    found_next = 1'b0;
                    cur_next   = '0;
                    if (req.action == fpba_pkg::ACT_FREE)
                    begin
                        i_next     = CW'(1);
                        state_next = fpba_pkg::ST_FSCAN;
                    end
                    else if (EW'(req.request_size) >= EW'(chunk)
                             || fm_reg == fpba_pkg::FIT_UNUSED)
                    begin
                        res_next.fail_cause = fpba_pkg::CAUSE_NO_FIT;
                        state_next          = fpba_pkg::ST_DONE;
                    end
                    else if (count_reg >= CW'(MAX_BLOCKS))
                    begin
                        res_next.fail_cause = fpba_pkg::CAUSE_FULL;
                        state_next          = fpba_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = fpba_pkg::ST_SCAN;
                    end
                end
            end

            fpba_pkg::ST_SCAN:
            begin
                mem_raddr = rv_reg ? AW'(i_reg + CW'(2)) : AW'(i_reg + CW'(1));
                rv_next   = rv_reg ? ((i_reg + CW'(2)) < count_reg)
                                   : ((i_reg + CW'(1)) < count_reg);
                if (rv_reg || last)
                begin
                    if (take)
                    begin
                        found_next = 1'b1;
                        pick_next  = i_reg;
                        pg_next    = gap;
                        here_next  = cur_end;
                    end
                    if (rv_reg)
                    begin
                        cur_next = mem_rdata;
                        i_next   = i_reg + CW'(1);
                    end
                    if (last || (take && fm_reg == fpba_pkg::FIT_FIRST))
                    begin
                        rv_next = 1'b0;
                        i_next  = count_reg - CW'(1);
                        if (take || found_reg)
                        begin
                            state_next = fpba_pkg::ST_SHUP;
                        end
                        else
                        begin
                            res_next.fail_cause = fpba_pkg::CAUSE_NO_FIT;
                            state_next          = fpba_pkg::ST_DONE;
                        end
                    end
                end
            end

            fpba_pkg::ST_SHUP:
            begin
                mem_raddr = i_reg[AW-1:0];
                mem_we    = rv_reg;
                if (i_reg > pick_reg)
                begin
                    wa_next = i_reg + CW'(1);
                    i_next  = i_reg - CW'(1);
                    rv_next = 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                    if (!rv_reg)
                    begin
                        state_next = fpba_pkg::ST_PUT;
                    end
                end
            end

            fpba_pkg::ST_PUT:
            begin
                mem_we                  = 1'b1;
                mem_waddr               = AW'(pick_reg + CW'(1));
                mem_wdata.start         = here_reg[OB-1:0];
                mem_wdata.len           = q_reg.request_size;
                count_next              = count_reg + CW'(1);
                res_next.ok             = 1'b1;
                res_next.payload_offset = OB'(here_reg + EW'(HEADER_BYTES));
                state_next              = fpba_pkg::ST_DONE;
            end

            fpba_pkg::ST_FSCAN:
            begin
                mem_raddr = i_reg[AW-1:0];
                rv_next   = i_reg < count_reg;
                wa_next   = i_reg;
                if (i_reg < count_reg)
                begin
                    i_next = i_reg + CW'(1);
                end
                if (rv_reg && (EW'(mem_rdata.start) + EW'(HEADER_BYTES)
                               == EW'(q_reg.block_offset)))
                begin
                    i_next     = wa_reg + CW'(1);
                    wa_next    = wa_reg;
                    rv_next    = 1'b0;
                    state_next = fpba_pkg::ST_SHDN;
                end
                else if (!rv_reg && i_reg >= count_reg)
                begin
                    res_next.fail_cause = fpba_pkg::CAUSE_UNKNOWN;
                    state_next          = fpba_pkg::ST_DONE;
                end
            end

            fpba_pkg::ST_SHDN:
            begin
                mem_raddr = i_reg[AW-1:0];
                mem_we    = rv_reg;
                if (i_reg < count_reg)
                begin
                    wa_next = i_reg - CW'(1);
                    i_next  = i_reg + CW'(1);
                    rv_next = 1'b1;
                end
                else
                begin
                    rv_next = 1'b0;
                    if (!rv_reg)
                    begin
                        count_next  = count_reg - CW'(1);
                        res_next.ok = 1'b1;
                        state_next  = fpba_pkg::ST_DONE;
                    end
                end
            end

            fpba_pkg::ST_DONE:
            begin
                if (!ov_reg || !rsp_stall)
                begin
                    ov_next    = 1'b1;
                    out_next   = res_reg;
                    state_next = fpba_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = fpba_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fpba_pkg::ST_IDLE;
            fm_reg    <= fpba_pkg::FIT_FIRST;
            kib_reg   <= KB'(1024);
            count_reg <= CW'(1);
            rv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fm_reg    <= fm_next;
            kib_reg   <= kib_next;
            count_reg <= count_next;
            rv_reg    <= rv_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        wa_reg    <= wa_next;
        found_reg <= found_next;
        pick_reg  <= pick_next;
        pg_reg    <= pg_next;
        here_reg  <= here_next;
        cur_reg   <= cur_next;
        q_reg     <= q_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

endmodule

// File: dv/fit_policy_block_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_unit_tb
// Self-checking bench for the block allocator: a scoreboard keeps its own
// copy of the block table and predicts every response. Directed cases cover
// the chunk end, the sentinel, unknown offsets, oversized requests and the
// odd register values. Random phases then mix allocates and frees, mostly
// of live blocks, under several fit methods and chunk sizes, with bursty
// requests and a stalling response side.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_unit_tb;

    localparam int NBLK = fpba_pkg::MAX_BLOCKS_DEF;
    localparam int HDR  = fpba_pkg::HEADER_BYTES_DEF;
    localparam int OB   = fpba_pkg::OFFSET_BITS;
    localparam int KB   = fpba_pkg::KIB_BITS;

    class alloc_scoreboard;
        fpba_pkg::fit_t fit;
        logic [10:0]    kib;
        longint         blk_start [NBLK];
        longint         blk_len [NBLK];
        int             count;
        fpba_pkg::rsp_t expected_q [$];
        int             errors;
        int             n_checked;
        int             n_ok;
        int             n_cause [4];

        function new();
            fit = fpba_pkg::FIT_FIRST;
            kib = 11'd1024;
            count = 1;
            blk_start[0] = 0;
            blk_len[0] = 0;
        endfunction

        function longint chunk_bytes();
            longint b;
            longint lim;
            lim = longint'(1) << OB;
            b = longint'(kib) * 1024;
            return (b > lim) ? lim : b;
        endfunction

        function void configure(fpba_pkg::cfg_reg_t idx, logic [10:0] data);
            if (idx == fpba_pkg::REG_FIT_METHOD)
            begin
                fit = fpba_pkg::fit_t'(data[1:0]);
            end
            else if (idx == fpba_pkg::REG_CHUNK_KIB)
            begin
                kib = data;
                count = 1;
            end
        endfunction

        function longint gap_after(int i);
            longint lim;
            lim = (i + 1 < count) ? blk_start[i + 1] : chunk_bytes();
            return lim - (blk_start[i] + HDR + blk_len[i]);
        endfunction

        function fpba_pkg::rsp_t allocate(longint size);
            fpba_pkg::rsp_t r;
            int             pick;
            bit             found;
            longint         pick_gap;
            longint         g;
            longint         here;
            r = '0;
            found = 0;
            pick = 0;
            pick_gap = 0;
            if (size >= chunk_bytes() || fit == fpba_pkg::FIT_UNUSED)
            begin
                r.fail_cause = fpba_pkg::CAUSE_NO_FIT;
                return r;
            end
            if (count >= NBLK)
            begin
                r.fail_cause = fpba_pkg::CAUSE_FULL;
                return r;
            end
            for (int i = 0; i < count; i++)
            begin
                g = gap_after(i);
                if (g >= size + HDR &&
                    (!found || (fit == fpba_pkg::FIT_BEST && g < pick_gap) ||
                     (fit == fpba_pkg::FIT_WORST && g > pick_gap)))
                begin
                    found = 1;
                    pick = i;
                    pick_gap = g;
                    if (fit == fpba_pkg::FIT_FIRST)
                        break;
                end
            end
            if (!found)
            begin
                r.fail_cause = fpba_pkg::CAUSE_NO_FIT;
                return r;
            end
            here = blk_start[pick] + HDR + blk_len[pick];
            for (int i = count; i > pick + 1; i--)
            begin
                blk_start[i] = blk_start[i - 1];
                blk_len[i] = blk_len[i - 1];
            end
            blk_start[pick + 1] = here;
            blk_len[pick + 1] = size;
            count++;
            r.ok = 1'b1;
            r.payload_offset = OB'(here + HDR);
            return r;
        endfunction

        function fpba_pkg::rsp_t release_block(longint off);
            fpba_pkg::rsp_t r;
            r = '0;
            for (int i = 1; i < count; i++)
            begin
                if (blk_start[i] + HDR == off)
                begin
                    for (int j = i; j + 1 < count; j++)
                    begin
                        blk_start[j] = blk_start[j + 1];
                        blk_len[j] = blk_len[j + 1];
                    end
                    count--;
                    r.ok = 1'b1;
                    return r;
                end
            end
            r.fail_cause = fpba_pkg::CAUSE_UNKNOWN;
            return r;
        endfunction

        function void note_request(fpba_pkg::req_t q);
            if (q.action == fpba_pkg::ACT_ALLOC)
                expected_q.push_back(allocate(longint'(q.request_size)));
            else
                expected_q.push_back(release_block(longint'(q.block_offset)));
        endfunction

        function void check_result(fpba_pkg::rsp_t got);
            fpba_pkg::rsp_t want;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response %p", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.ok)
                n_ok++;
            n_cause[want.fail_cause]++;
            if (got.ok !== want.ok)
            begin
                $error("ok: expected %0d actual %0d", want.ok, got.ok);
                errors++;
            end
            if (got.payload_offset !== want.payload_offset)
            begin
                $error("payload_offset: expected %0d actual %0d",
                       want.payload_offset, got.payload_offset);
                errors++;
            end
            if (got.fail_cause !== want.fail_cause)
            begin
                $error("fail_cause: expected %0d actual %0d",
                       want.fail_cause, got.fail_cause);
                errors++;
            end
        endfunction

        function longint live_offset();
            return blk_start[$urandom_range(count - 1, 1)] + HDR;
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [fpba_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [KB-1:0]                       cfg_data = '0;
    logic                                req_valid = 1'b0;
    logic                                req_stall;
    fpba_pkg::req_t                      req = '0;
    logic                                rsp_valid;
    logic                                rsp_stall = 1'b0;
    fpba_pkg::rsp_t                      rsp;

    alloc_scoreboard sb = new();
    int              stall_mode = 0;
    int              n_cfg = 0;

    fit_policy_block_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && req_valid && !req_stall)
            sb.note_request(req);
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_result(rsp);
    end

    // receiver stall pattern: switch mode now and then
    always @(posedge clk)
    begin
        if ($urandom_range(299, 0) == 0)
            stall_mode <= $urandom_range(3, 0);
        unique case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(3, 0) == 0);
            2: rsp_stall <= ($urandom_range(3, 0) != 0);
            default: rsp_stall <= ($urandom_range(15, 0) != 0);
        endcase
    end

    task automatic send(input logic act, input longint size, input longint off);
        fpba_pkg::req_t q;
        q.action = act;
        q.request_size = OB'(size);
        q.block_offset = OB'(off);
        req_valid <= 1'b1;
        req <= q;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic idle(input int n);
        req_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input fpba_pkg::cfg_reg_t idx, input int data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= KB'(data);
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.configure(idx, KB'(data));
        cfg_valid <= 1'b0;
        n_cfg++;
        @(posedge clk);
    endtask

    task automatic random_phase(input int items, input int alloc_pct, input int max_size);
        int     burst;
        int     sent;
        longint size;
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(12, 1);
            for (int b = 0; b < burst && sent < items; b++)
            begin
                if ($urandom_range(99, 0) < alloc_pct)
                begin
                    size = ($urandom_range(19, 0) == 0) ? longint'($urandom_range(1048575, 0))
                                                        : longint'($urandom_range(max_size, 0));
                    send(fpba_pkg::ACT_ALLOC, size, $urandom_range(1048575, 0));
                end
                else if (sb.count > 1 && $urandom_range(9, 0) != 0)
                    send(fpba_pkg::ACT_FREE, $urandom_range(1048575, 0), sb.live_offset());
                else
                    send(fpba_pkg::ACT_FREE, $urandom_range(1048575, 0),
                         $urandom_range(1048575, 0));
                sent++;
            end
            if ($urandom_range(2, 0) != 0)
                idle($urandom_range(20, 1));
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(fpba_pkg::ACT_ALLOC, (1 << 20) - 72, 0);
        send(fpba_pkg::ACT_ALLOC, 0, 0);
        send(fpba_pkg::ACT_ALLOC, 0, 0);
        send(fpba_pkg::ACT_ALLOC, 20'hFFFFF, 0);
        send(fpba_pkg::ACT_FREE, 20'hFFFFF, 0);
        send(fpba_pkg::ACT_FREE, 0, HDR);
        send(fpba_pkg::ACT_FREE, 0, 20'hFFFFF);
        send(fpba_pkg::ACT_FREE, 0, 2 * HDR);
        send(fpba_pkg::ACT_ALLOC, 100, 0);
        write_reg(fpba_pkg::REG_FIT_METHOD, fpba_pkg::FIT_UNUSED);
        send(fpba_pkg::ACT_ALLOC, 10, 0);
        write_reg(fpba_pkg::REG_SPARE2, 5);
        write_reg(fpba_pkg::REG_SPARE3, 1);
        send(fpba_pkg::ACT_ALLOC, 10, 0);
        write_reg(fpba_pkg::REG_FIT_METHOD, fpba_pkg::FIT_BEST);
        write_reg(fpba_pkg::REG_CHUNK_KIB, 0);
        send(fpba_pkg::ACT_ALLOC, 0, 0);
        write_reg(fpba_pkg::REG_CHUNK_KIB, 2047);
        send(fpba_pkg::ACT_ALLOC, (1 << 20) - 1, 0);
        send(fpba_pkg::ACT_ALLOC, (1 << 20) - 48, 0);
        write_reg(fpba_pkg::REG_CHUNK_KIB, 1);
        send(fpba_pkg::ACT_ALLOC, 1023, 0);
        send(fpba_pkg::ACT_ALLOC, 1000, 0);
        send(fpba_pkg::ACT_ALLOC, 1001, 0);

        for (int p = 0; p < 8; p++)
        begin
            write_reg(fpba_pkg::REG_FIT_METHOD, (p == 7) ? fpba_pkg::FIT_UNUSED : p % 3);
            unique case (p)
                0: write_reg(fpba_pkg::REG_CHUNK_KIB, 1024);
                1: write_reg(fpba_pkg::REG_CHUNK_KIB, 1);
                2: write_reg(fpba_pkg::REG_CHUNK_KIB, 4);
                3: write_reg(fpba_pkg::REG_CHUNK_KIB, 2047);
                4: write_reg(fpba_pkg::REG_CHUNK_KIB, 16);
                5: write_reg(fpba_pkg::REG_CHUNK_KIB, 2);
                default: write_reg(fpba_pkg::REG_CHUNK_KIB, $urandom_range(2047, 1));
            endcase
            random_phase(90, (p % 2) ? 60 : 80, (p == 3) ? 40000 : 300);
            drain();
            random_phase(90, 55, (p == 1) ? 100 : 2000);
        end
        drain();

        $display("checked %0d responses over %0d register writes: %0d ok, %0d no fit,",
                 sb.n_checked, n_cfg, sb.n_ok, sb.n_cause[fpba_pkg::CAUSE_NO_FIT]);
        $display("  %0d table full, %0d unknown offset",
                 sb.n_cause[fpba_pkg::CAUSE_FULL], sb.n_cause[fpba_pkg::CAUSE_UNKNOWN]);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
sv/fpba_pkg.sv
sv/fpba_ram.sv
sv/fit_policy_block_allocator_unit.sv
dv/fit_policy_block_allocator_unit_tb.sv
